### rtl/gbt_pkg.sv
// ----------------------------------------------------------------------------
// gbt_pkg
// Shared types and codes for the graph traversal engine: command and result
// beats, opcodes, status codes, and the controller/datapath interface.
// ----------------------------------------------------------------------------
package gbt_pkg;

    localparam logic [1:0] OP_ADD  = 2'd0;
    localparam logic [1:0] OP_BFS  = 2'd1;
    localparam logic [1:0] OP_DFS  = 2'd2;
    localparam logic [1:0] OP_NONE = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam int unsigned CFG_W = 7;
    localparam int unsigned VTX_W = 6;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [VTX_W-1:0] first_vertex;
        logic [VTX_W-1:0] second_vertex;
    } cmd_t;

    typedef struct packed {
        logic [VTX_W-1:0] vertex;
        logic             last;
        logic [1:0]       status;
    } res_t;

    // commands from controller to datapath
    typedef struct packed {
        logic       load;
        logic       trav_init;
        logic       rd_head_b;
        logic       wr_a;
        logic       wr_b;
        logic       pop;
        logic       take_cur;
        logic       rd_edge_head;
        logic       scan;
        logic       finish;
        logic       emit_status;
        logic [1:0] status;
    } ctrl_t;

    // status from datapath to controller
    typedef struct packed {
        logic [1:0] op;
        logic       a_err;
        logic       b_err;
        logic       full;
        logic       wl_empty;
        logic       head_vld;
        logic       link_empty;
    } stat_t;

endpackage

### rtl/graph_bfs_dfs_traversal_top.sv
// ----------------------------------------------------------------------------
// graph_bfs_dfs_traversal_top
// Undirected graph engine: edge insertion plus breadth-first and depth-first
// traversal. A command is taken when start is high and busy is low. An add
// gives one result beat; a traversal gives one beat per reachable vertex in
// visit order, last set on the final one. Results are one-cycle strobes on
// result_valid and cannot be stalled. The run time of a traversal is set by
// the single read port of the edge store, walked one entry per cycle.
// vertex_count may be written only while idle.
// ----------------------------------------------------------------------------
module graph_bfs_dfs_traversal_top
    import gbt_pkg::*;
#(
    parameter int MAX_VERTICES     = 64,
    parameter int MAX_EDGE_ENTRIES = 256
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  cmd_t             cmd,
    output logic             result_valid,
    output res_t             result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data
);

    ctrl_t ctl;
    stat_t sts;

    // register writes are always taken
    assign cfg_ready = 1'b1;

    // sequencer
    gbt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .ctl   (ctl)
    );

    // storage and result path
    gbt_datapath #(
        .MAX_VERTICES     (MAX_VERTICES),
        .MAX_EDGE_ENTRIES (MAX_EDGE_ENTRIES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .ctl          (ctl),
        .sts          (sts),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

### rtl/gbt_datapath.sv
// ----------------------------------------------------------------------------
// gbt_datapath
// Edge store, list heads, work list, visited marks and result register.
// Carries out one controller command per cycle.
// ----------------------------------------------------------------------------
module gbt_datapath
    import gbt_pkg::*;
#(
    parameter int MAX_VERTICES     = 64,
    parameter int MAX_EDGE_ENTRIES = 256
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cmd_t             cmd,
    input  logic             cfg_valid,
    input  logic [CFG_W-1:0] cfg_data,
    input  ctrl_t            ctl,
    output stat_t            sts,
    output logic             result_valid,
    output res_t             result
);

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int EW = $clog2(MAX_EDGE_ENTRIES);
    localparam int LW = EW + 1;
    localparam int PW = $clog2(MAX_VERTICES + 1);
    localparam logic [LW-1:0]    EMPTY_LINK = LW'(MAX_EDGE_ENTRIES);
    localparam logic [CFG_W-1:0] MAXV_C     = CFG_W'(MAX_VERTICES);

    // storage
    logic [EW-1:0]          head_mem [MAX_VERTICES];
    logic [VTX_W+LW-1:0]    edge_mem [MAX_EDGE_ENTRIES];
    logic [VTX_W-1:0]       wl_mem   [MAX_VERTICES];

    logic [CFG_W-1:0]        cfg_reg;
    logic [MAX_VERTICES-1:0] head_vld_reg;
    logic [MAX_VERTICES-1:0] vis_reg;
    logic [LW-1:0]           used_reg;
    logic [PW-1:0]           front_reg;
    logic [PW-1:0]           back_reg;
    logic                    pend_vld_reg;
    logic [VTX_W-1:0]        cur_reg;
    logic [1:0]              op_reg;
    logic [VTX_W-1:0]        a_reg;
    logic [VTX_W-1:0]        b_reg;
    logic [EW-1:0]           head_q_reg;
    logic                    head_q_vld_reg;
    logic [VTX_W+LW-1:0]     edge_q_reg;
    logic [VTX_W-1:0]        wl_q_reg;
    logic                    res_valid_reg;
    res_t                    res_reg;

    logic [CFG_W-1:0] n_act;
    logic [VTX_W-1:0] tgt_q;
    logic [LW-1:0]    link_q;
    logic             push;
    logic [VW-1:0]    head_addr;
    logic [EW-1:0]    edge_addr;
    logic [VW-1:0]    pop_addr;
    logic [VTX_W-1:0] new_tgt;
    logic [LW-1:0]    new_link;
    logic             dfs;

    // active vertex count, clamped
    always_comb
    begin
        if (cfg_reg == '0)
            n_act = CFG_W'(1);
        else if (cfg_reg > MAXV_C)
            n_act = MAXV_C;
        else
            n_act = cfg_reg;
    end

    assign dfs      = (op_reg == OP_DFS);
    assign tgt_q    = edge_q_reg[VTX_W+LW-1:LW];
    assign link_q   = edge_q_reg[LW-1:0];
    assign push     = ctl.scan && ({1'b0, tgt_q} < n_act) && !vis_reg[tgt_q[VW-1:0]];
    assign new_tgt  = ctl.wr_a ? b_reg : a_reg;
    assign new_link = head_q_vld_reg ? {1'b0, head_q_reg} : EMPTY_LINK;

    // read address selection
    always_comb
    begin
        if (ctl.rd_head_b)
            head_addr = b_reg[VW-1:0];
        else if (ctl.take_cur)
            head_addr = wl_q_reg[VW-1:0];
        else
            head_addr = a_reg[VW-1:0];
        edge_addr = ctl.rd_edge_head ? head_q_reg : link_q[EW-1:0];
        pop_addr  = dfs ? VW'(back_reg - PW'(1)) : front_reg[VW-1:0];
    end

    // status to controller
    always_comb
    begin
        sts.op         = op_reg;
        sts.a_err      = ({1'b0, a_reg} >= n_act);
        sts.b_err      = ({1'b0, b_reg} >= n_act);
        sts.full       = ({1'b0, used_reg} + (LW+1)'(2)) > (LW+1)'(MAX_EDGE_ENTRIES);
        sts.wl_empty   = (front_reg == back_reg);
        sts.head_vld   = head_q_vld_reg;
        sts.link_empty = (link_q == EMPTY_LINK);
    end

    // memories and payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            op_reg <= cmd.opcode;
            a_reg  <= cmd.first_vertex;
            b_reg  <= cmd.second_vertex;
        end
        if (ctl.wr_a)
            head_mem[a_reg[VW-1:0]] <= used_reg[EW-1:0];
        else if (ctl.wr_b)
            head_mem[b_reg[VW-1:0]] <= used_reg[EW-1:0];
        head_q_reg     <= head_mem[head_addr];
        head_q_vld_reg <= head_vld_reg[head_addr];
        if (ctl.wr_a || ctl.wr_b)
            edge_mem[used_reg[EW-1:0]] <= {new_tgt, new_link};
        edge_q_reg <= edge_mem[edge_addr];
        if (ctl.trav_init)
            wl_mem[0] <= a_reg;
        else if (push)
            wl_mem[back_reg[VW-1:0]] <= tgt_q;
        wl_q_reg <= wl_mem[pop_addr];
        if (ctl.take_cur)
            cur_reg <= wl_q_reg;
        if (ctl.take_cur || ctl.finish)
        begin
            res_reg.vertex <= cur_reg;
            res_reg.last   <= ctl.finish;
            res_reg.status <= ST_OK;
        end
        else if (ctl.emit_status)
        begin
            res_reg.vertex <= '0;
            res_reg.last   <= 1'b1;
            res_reg.status <= ctl.status;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= MAXV_C;
            head_vld_reg  <= '0;
            vis_reg       <= '0;
            used_reg      <= '0;
            front_reg     <= '0;
            back_reg      <= '0;
            pend_vld_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                cfg_reg <= cfg_data;
            if (ctl.wr_a)
                head_vld_reg[a_reg[VW-1:0]] <= 1'b1;
            if (ctl.wr_b)
                head_vld_reg[b_reg[VW-1:0]] <= 1'b1;
            if (ctl.wr_a || ctl.wr_b)
                used_reg <= used_reg + LW'(1);
            // traversal start: one mark, one queued vertex
            if (ctl.trav_init)
            begin
                vis_reg      <= {{(MAX_VERTICES-1){1'b0}}, 1'b1} << a_reg[VW-1:0];
                front_reg    <= '0;
                back_reg     <= PW'(1);
                pend_vld_reg <= 1'b0;
            end
            else
            begin
                if (push)
                begin
                    vis_reg[tgt_q[VW-1:0]] <= 1'b1;
                    back_reg               <= back_reg + PW'(1);
                end
                else if (ctl.pop && dfs)
                    back_reg <= back_reg - PW'(1);
                if (ctl.pop && !dfs)
                    front_reg <= front_reg + PW'(1);
                if (ctl.take_cur)
                    pend_vld_reg <= 1'b1;
            end
            res_valid_reg <= (ctl.take_cur && pend_vld_reg) || ctl.finish || ctl.emit_status;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    // checks
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= LW'(MAX_EDGE_ENTRIES))
        else $error("edge store count overflow");
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> back_reg < PW'(MAX_VERTICES))
        else $error("work list overflow");
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.emit_status |=> result_valid && result.last)
        else $error("status beat without last");
    a_fin_pend: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.finish |-> pend_vld_reg)
        else $error("run ended with no vertex");

endmodule

### rtl/gbt_ctrl.sv
// ----------------------------------------------------------------------------
// gbt_ctrl
// Sequencer for edge insertion and traversal; drives datapath commands.
// ----------------------------------------------------------------------------
module gbt_ctrl
    import gbt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    output logic  busy,
    input  stat_t sts,
    output ctrl_t ctl
);

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_ADD_WR_A, S_ADD_RD_B, S_ADD_WR_B,
        S_POP, S_CUR, S_HEAD, S_EDGE
    } state_t;

    state_t state_reg, state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                priority if (sts.op == OP_NONE)
                    state_next = S_IDLE;
                else if (sts.op == OP_ADD)
                begin
                    if (sts.a_err || sts.b_err)
                    begin
                        ctl.emit_status = 1'b1;
                        ctl.status      = ST_RANGE;
                        state_next      = S_IDLE;
                    end
                    else if (sts.full)
                    begin
                        ctl.emit_status = 1'b1;
                        ctl.status      = ST_FULL;
                        state_next      = S_IDLE;
                    end
                    else
                        state_next = S_ADD_WR_A;
                end
                else if (sts.a_err)
                begin
                    ctl.emit_status = 1'b1;
                    ctl.status      = ST_RANGE;
                    state_next      = S_IDLE;
                end
                else
                begin
                    ctl.trav_init = 1'b1;
                    state_next    = S_POP;
                end
            end
            S_ADD_WR_A:
            begin
                ctl.wr_a   = 1'b1;
                state_next = S_ADD_RD_B;
            end
            S_ADD_RD_B:
            begin
                ctl.rd_head_b = 1'b1;
                state_next    = S_ADD_WR_B;
            end
            S_ADD_WR_B:
            begin
                ctl.wr_b        = 1'b1;
                ctl.emit_status = 1'b1;
                ctl.status      = ST_OK;
                state_next      = S_IDLE;
            end
            S_POP:
            begin
                if (sts.wl_empty)
                begin
                    ctl.finish = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    ctl.pop    = 1'b1;
                    state_next = S_CUR;
                end
            end
            S_CUR:
            begin
                ctl.take_cur = 1'b1;
                state_next   = S_HEAD;
            end
            S_HEAD:
            begin
                if (sts.head_vld)
                begin
                    ctl.rd_edge_head = 1'b1;
                    state_next       = S_EDGE;
                end
                else
                    state_next = S_POP;
            end
            S_EDGE:
            begin
                ctl.scan = 1'b1;
                if (sts.link_empty)
                    state_next = S_POP;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != S_IDLE);

    // checks
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load |=> state_reg == S_DECODE)
        else $error("load did not lead to decode");
    a_add_seq: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.wr_a |=> ctl.rd_head_b ##1 ctl.wr_b)
        else $error("edge insert sequence broken");
    a_one_end: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.finish && ctl.emit_status))
        else $error("two result sources in one cycle");

endmodule

### bench/graph_bfs_dfs_traversal_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// graph_bfs_dfs_traversal_top_test
// Drives edge additions and breadth-first / depth-first traversals into the
// graph engine, predicts every result beat from a behavioral model of the
// edge store and work list, and compares the strobed results in order.
// ----------------------------------------------------------------------------
module graph_bfs_dfs_traversal_top_test;
    import gbt_pkg::*;

    localparam int NV = 64;
    localparam int NE = 256;
    localparam int WATCHDOG_LIMIT = 20000;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    cmd_t             cmd;
    logic             result_valid;
    res_t             result;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data;

    graph_bfs_dfs_traversal_top #(.MAX_VERTICES(NV), .MAX_EDGE_ENTRIES(NE)) i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .result_valid(result_valid), .result(result),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // graph shadow state
    int unsigned head_of[NV];
    int unsigned tgt_of[NE];
    int unsigned link_of[NE];
    int unsigned used_cnt;
    int unsigned vcount;

    cmd_t pending_cmds[$];
    res_t expected_beats[$];
    int   errors;
    int   gap_left;
    int   idle_cycles;
    bit   drained_hold;

    // stimulus control from the initial block
    bit   hold_off;
    bit   want_cfg;
    logic [CFG_W-1:0] cfg_value;

    function automatic int unsigned eff_count();
        if (vcount < 1) return 1;
        if (vcount > NV) return NV;
        return vcount;
    endfunction

    function automatic res_t mk(int unsigned v, bit l, logic [1:0] s);
        res_t r;
        r.vertex = v[VTX_W-1:0];
        r.last   = l;
        r.status = s;
        return r;
    endfunction

    // predict the result beats of one accepted command
    task automatic predict_cmd(cmd_t c);
        int unsigned n, a, b, cur, e, steps, front, back, t, k;
        bit seen[NV];
        int unsigned wl[NV];
        n = eff_count();
        a = c.first_vertex;
        b = c.second_vertex;
        k = 0;
        if (c.opcode == OP_NONE) return;
        if (c.opcode == OP_ADD) begin
            if (a >= n || b >= n) expected_beats.push_back(mk(0, 1, ST_RANGE));
            else if (used_cnt + 2 > NE) expected_beats.push_back(mk(0, 1, ST_FULL));
            else begin
                tgt_of[used_cnt] = b; link_of[used_cnt] = head_of[a];
                head_of[a] = used_cnt; used_cnt++;
                tgt_of[used_cnt] = a; link_of[used_cnt] = head_of[b];
                head_of[b] = used_cnt; used_cnt++;
                expected_beats.push_back(mk(0, 1, ST_OK));
            end
            return;
        end
        if (a >= n) begin
            expected_beats.push_back(mk(0, 1, ST_RANGE));
            return;
        end
        foreach (seen[i]) seen[i] = 0;
        front = 0; back = 0;
        wl[back++] = a;
        seen[a] = 1;
        while (front < back) begin
            if (c.opcode == OP_DFS) begin
                back--;
                cur = wl[back];
            end
            else begin
                cur = wl[front];
                front++;
            end
            expected_beats.push_back(mk(cur, 0, ST_OK));
            k++;
            e = head_of[cur];
            steps = 0;
            while (e < NE && steps < used_cnt) begin
                t = tgt_of[e];
                if (t < n && !seen[t] && back < NV) begin
                    seen[t] = 1;
                    wl[back++] = t;
                end
                e = link_of[e];
                steps++;
            end
        end
        expected_beats[$].last = 1;
    endtask

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // command driver
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            start    <= 0;
            cmd      <= '0;
            gap_left <= 0;
        end
        else if (start && !busy) begin
            predict_cmd(cmd);
            start <= 0;
            gap_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60)
                                                    : $urandom_range(0, 2);
        end
        else if (!start) begin
            if (gap_left > 0) gap_left <= gap_left - 1;
            else if (!hold_off && !want_cfg && pending_cmds.size() > 0) begin
                cmd   <= pending_cmds.pop_front();
                start <= 1;
            end
        end
    end

    // config writer
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cfg_valid <= 0;
            cfg_data  <= '0;
        end
        else if (cfg_valid && cfg_ready) begin
            vcount = cfg_data;
            cfg_valid <= 0;
            want_cfg  <= 0;
        end
        else if (want_cfg && !cfg_valid) begin
            cfg_data  <= cfg_value;
            cfg_valid <= 1;
        end
    end

    // result monitor and watchdog
    always @(posedge clk or negedge rst_n) begin
        res_t exp_r;
        if (!rst_n) idle_cycles <= 0;
        else begin
            if (result_valid) begin
                if (expected_beats.size() == 0) begin
                    $display("%0t: unexpected result beat %p", $time, result);
                    errors++;
                end
                else begin
                    exp_r = expected_beats.pop_front();
                    if (result.vertex !== exp_r.vertex || result.last !== exp_r.last
                        || result.status !== exp_r.status) begin
                        $display("%0t: mismatch expected %p actual %p", $time, exp_r, result);
                        errors++;
                    end
                end
            end
            if (result_valid || (start && !busy) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    function automatic cmd_t mkcmd(logic [1:0] op, int unsigned a, int unsigned b);
        cmd_t c;
        c.opcode = op;
        c.first_vertex = a[VTX_W-1:0];
        c.second_vertex = b[VTX_W-1:0];
        return c;
    endfunction

    // wait until all queued work has finished and the engine is quiet
    task automatic drain();
        while (pending_cmds.size() > 0 || start || expected_beats.size() > 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
        while (pending_cmds.size() > 0 || start || busy || expected_beats.size() > 0)
            @(posedge clk);
    endtask

    task automatic write_count(int unsigned v);
        drain();
        cfg_value = v[CFG_W-1:0];
        want_cfg = 1;
        while (want_cfg) @(posedge clk);
    endtask

    // a phase of random commands, mostly edges within a small range
    task automatic random_phase(int cnt, int unsigned span);
        int unsigned r;
        repeat (cnt) begin
            r = $urandom_range(0, 19);
            if (r < 11)
                pending_cmds.push_back(mkcmd(OP_ADD, $urandom_range(0, span - 1),
                                             $urandom_range(0, span - 1)));
            else if (r < 15)
                pending_cmds.push_back(mkcmd(OP_BFS, $urandom_range(0, span - 1), $urandom));
            else if (r < 19)
                pending_cmds.push_back(mkcmd(OP_DFS, $urandom_range(0, span - 1), $urandom));
            else
                pending_cmds.push_back(mkcmd(2'($urandom_range(0, 3)), $urandom, $urandom));
        end
    endtask

    initial begin
        errors = 0;
        hold_off = 0;
        want_cfg = 0;
        cfg_value = '0;
        foreach (head_of[i]) head_of[i] = NE;
        used_cnt = 0;
        vcount = 64;
        rst_n = 0;
        start = 0;
        cmd = '0;
        cfg_valid = 0;
        cfg_data = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1;

        // directed: extremes, every opcode, range errors, self-loop
        pending_cmds.push_back(mkcmd(OP_BFS, 0, 0));
        pending_cmds.push_back(mkcmd(OP_ADD, 0, 63));
        pending_cmds.push_back(mkcmd(OP_ADD, 5, 5));
        pending_cmds.push_back(mkcmd(OP_ADD, 63, 5));
        pending_cmds.push_back(mkcmd(OP_ADD, 0, 1));
        pending_cmds.push_back(mkcmd(OP_ADD, 1, 2));
        pending_cmds.push_back(mkcmd(OP_NONE, 63, 63));
        pending_cmds.push_back(mkcmd(OP_BFS, 0, 63));
        pending_cmds.push_back(mkcmd(OP_DFS, 0, 0));
        pending_cmds.push_back(mkcmd(OP_DFS, 63, 42));
        drain();
        write_count(4);
        pending_cmds.push_back(mkcmd(OP_ADD, 4, 1));
        pending_cmds.push_back(mkcmd(OP_ADD, 1, 63));
        pending_cmds.push_back(mkcmd(OP_BFS, 4, 0));
        pending_cmds.push_back(mkcmd(OP_BFS, 0, 0));
        pending_cmds.push_back(mkcmd(OP_DFS, 1, 0));
        write_count(0);
        pending_cmds.push_back(mkcmd(OP_ADD, 0, 0));
        pending_cmds.push_back(mkcmd(OP_ADD, 0, 1));
        pending_cmds.push_back(mkcmd(OP_DFS, 0, 0));
        pending_cmds.push_back(mkcmd(OP_BFS, 1, 0));
        write_count(127);
        pending_cmds.push_back(mkcmd(OP_BFS, 63, 0));

        // random phases over several vertex counts
        random_phase(70, 8);
        write_count(16);
        random_phase(60, 16);
        // sender waits for every result before going on
        drain();
        write_count(64);
        random_phase(80, 64);
        drain();
        write_count(2);
        random_phase(30, 4);
        write_count(64);
        random_phase(60, 64);
        // fill the edge store to reach the full status
        while (used_cnt + 2 <= NE && pending_cmds.size() < 200)
            begin
                pending_cmds.push_back(mkcmd(OP_ADD, $urandom_range(0, 63),
                                             $urandom_range(0, 63)));
                drain();
            end
        random_phase(40, 64);
        write_count(100);
        random_phase(20, 64);

        drain();
        if (errors == 0 && expected_beats.size() == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end
endmodule

### filelist.f
rtl/gbt_pkg.sv
rtl/gbt_datapath.sv
rtl/gbt_ctrl.sv
rtl/graph_bfs_dfs_traversal_top.sv
bench/graph_bfs_dfs_traversal_top_test.sv
